// ===== hw/rtl/msps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_pkg: shared definitions for the masked byte pattern scanner
// Register indexes, field widths and the flag bundle from the compare unit.
// ----------------------------------------------------------------------------
package msps_pkg;

	// parameter defaults
	localparam int MAX_PATTERN_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	// field widths
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 5;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int POS_W     = 32;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH     = 3'd0,
		REG_PATTERN_VALUE_LOW  = 3'd1,
		REG_PATTERN_VALUE_HIGH = 3'd2,
		REG_PATTERN_MASK_LOW   = 3'd3,
		REG_PATTERN_MASK_HIGH  = 3'd4
	} cfg_reg_t;

	// flags from the window compare unit
	typedef struct packed {
		logic hit;
		logic trivial;
	} match_flags_t;

endpackage : msps_pkg
`default_nettype wire

// ===== hw/rtl/msps_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps channel interfaces
// Valid/ready channels for input bytes and scan results.
// ----------------------------------------------------------------------------
interface msps_byte_if;
	import msps_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_sequence;

	modport source (output valid, output data_byte, output end_of_sequence, input ready);
	modport sink   (input valid, input data_byte, input end_of_sequence, output ready);
endinterface : msps_byte_if

interface msps_result_if;
	import msps_pkg::*;

	logic             valid;
	logic             ready;
	logic             match_found;
	logic [POS_W-1:0] match_position;
	logic             scan_done;

	modport source (output valid, output match_found, output match_position,
		output scan_done, input ready);
	modport sink   (input valid, input match_found, input match_position,
		input scan_done, output ready);
endinterface : msps_result_if
`default_nettype wire

// ===== hw/rtl/msps_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_match: parallel masked compare of the byte window
// Aligns each pattern byte with its window byte and checks all lanes at once.
// ----------------------------------------------------------------------------
module msps_match #(
	parameter int MAX_PATTERN = msps_pkg::MAX_PATTERN_DEF
) (
	input  wire logic [8*MAX_PATTERN-1:0]  window,
	input  wire logic [msps_pkg::LEN_W-1:0] len,
	input  wire logic [127:0]               value,
	input  wire logic [127:0]               mask,
	output msps_pkg::match_flags_t          flags
);
	import msps_pkg::*;

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0] lane_ok;
	logic [MAX_PATTERN-1:0] lane_care;

	// one lane per pattern byte, window byte len-1-i lines up with pattern byte i
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
		logic             in_use;
		logic [LEN_W-1:0] lag;
		logic [IW-1:0]    sel;
		logic [7:0]       wb;
		logic [7:0]       vb;
		logic [7:0]       mb;

		assign in_use       = len > LEN_W'(i);
		assign lag          = len - LEN_W'(i) - LEN_W'(1);
		assign sel          = lag[IW-1:0];
		assign wb           = window[8*sel +: 8];
		assign vb           = value[8*i +: 8];
		assign mb           = mask[8*i +: 8];
		assign lane_ok[i]   = !in_use || (((wb ^ vb) & mb) == 8'd0);
		assign lane_care[i] = in_use && (mb != 8'd0);
	end

	// all lanes agree; no cared bit at all means a trivial pattern
	assign flags.hit     = &lane_ok;
	assign flags.trivial = ~|lane_care;

endmodule : msps_match
`default_nettype wire

// ===== hw/rtl/masked_byte_pattern_scanner_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core: wildcard byte signature scanner
// Each accepted byte shifts into the window and completes one start position.
// The result of a byte transfer is registered and shows in the next cycle.
// Throughput: one byte per cycle, set by the single compare pass per byte;
// a new byte is taken while a result is held only if that result transfers too.
// Reset clears the window, byte count, configuration registers and result valid.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_core #(
	parameter int MAX_PATTERN = msps_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH = msps_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	msps_byte_if.sink                          bytes,
	msps_result_if.source                      results,
	input  wire logic                          cfg_we,
	input  wire logic [msps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [msps_pkg::CFG_W-1:0]    cfg_data
);
	import msps_pkg::*;

	localparam int EXT_W = (COUNT_WIDTH > POS_W) ? COUNT_WIDTH : POS_W;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	// configuration registers
	logic [LEN_W-1:0] pattern_length_q;
	logic [127:0]     pattern_value_q;
	logic [127:0]     pattern_mask_q;

	// scan state
	logic [8*MAX_PATTERN-1:0] window_q;
	logic [COUNT_WIDTH-1:0]   seen_q;

	// result register
	logic             out_valid_q;
	logic             match_found_q;
	logic [POS_W-1:0] match_position_q;
	logic             scan_done_q;

	logic                       accept;
	logic [8*MAX_PATTERN+7:0]   shifted;
	logic [8*MAX_PATTERN-1:0]   window_nx;
	logic [LEN_W-1:0]           len_used;
	logic                       counted;
	logic [COUNT_WIDTH-1:0]     seen_nx;
	logic [COUNT_WIDTH-1:0]     len_ext;
	logic [COUNT_WIDTH-1:0]     start_pos;
	logic [EXT_W-1:0]           start_ext;
	match_flags_t               flags;
	logic                       found;
	logic                       produce;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			pattern_value_q  <= '0;
			pattern_mask_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LENGTH:     pattern_length_q       <= cfg_data[LEN_W-1:0];
				REG_PATTERN_VALUE_LOW:  pattern_value_q[63:0]  <= cfg_data;
				REG_PATTERN_VALUE_HIGH: pattern_value_q[127:64] <= cfg_data;
				REG_PATTERN_MASK_LOW:   pattern_mask_q[63:0]   <= cfg_data;
				REG_PATTERN_MASK_HIGH:  pattern_mask_q[127:64] <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: take a byte whenever the result slot is free or draining
	assign bytes.ready = !out_valid_q || results.ready;
	assign accept      = bytes.valid && bytes.ready;

	// window after this byte, newest at the bottom
	assign shifted   = {window_q, bytes.data_byte};
	assign window_nx = shifted[8*MAX_PATTERN-1:0];

	// used length clamps to the window depth
	assign len_used = (pattern_length_q > MAX_LEN) ? MAX_LEN : pattern_length_q;

	// saturating byte count
	assign counted = seen_q != {COUNT_WIDTH{1'b1}};
	assign seen_nx = seen_q + COUNT_WIDTH'(counted);
	assign len_ext = COUNT_WIDTH'(len_used);

	msps_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.window(window_nx),
		.len   (len_used),
		.value (pattern_value_q),
		.mask  (pattern_mask_q),
		.flags (flags)
	);

	// match decision for the start completed by this byte
	always_comb begin
		found = 1'b0;
		if (counted) begin
			if (flags.trivial) begin
				found = bytes.end_of_sequence && (len_used != '0) && (seen_nx == len_ext);
			end else begin
				found = (seen_nx >= len_ext) && flags.hit;
			end
		end
	end

	// trivial matches sit at offset zero, where this difference is zero as well
	assign start_pos = seen_nx - len_ext;
	assign start_ext = EXT_W'(start_pos);
	assign produce   = found || bytes.end_of_sequence;

	// window and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
		end else if (accept) begin
			window_q <= window_nx;
			seen_q   <= bytes.end_of_sequence ? '0 : seen_nx;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && produce) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && produce) begin
			match_found_q    <= found;
			match_position_q <= found ? start_ext[POS_W-1:0] : '0;
			scan_done_q      <= bytes.end_of_sequence;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.match_found    = match_found_q;
	assign results.match_position = match_position_q;
	assign results.scan_done      = scan_done_q;

endmodule : masked_byte_pattern_scanner_core
`default_nettype wire

// ===== hw/rtl/msps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msps_checker: port-level checks for the scanner
// Watches the byte and result channels and the result field encoding.
// ----------------------------------------------------------------------------
module msps_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_last,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        out_found,
	input wire logic [msps_pkg::POS_W-1:0]  out_position,
	input wire logic                        out_done
);
	import msps_pkg::*;

	// a held result stays until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// the last byte of a sequence gives a done result in the next cycle
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid && out_done)
		else $error("last byte gave no done result");

	// a result that is not done must carry a match
	a_mid_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_done |-> out_found)
		else $error("result without match before end of sequence");

	// a result without a match reports offset zero
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_position == '0)
		else $error("nonzero position without match");

endmodule : msps_checker

bind masked_byte_pattern_scanner_core msps_checker u_msps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (bytes.valid),
	.in_ready    (bytes.ready),
	.in_last     (bytes.end_of_sequence),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_found   (results.match_found),
	.out_position(results.match_position),
	.out_done    (results.scan_done)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the masked byte pattern scanner core
// Drives byte sequences through the input channel and checks every scan
// report against a cycle-free predictor of the window compare. Directed
// sequences cover exact, repeated, nibble-wildcard, empty, all-wildcard and
// oversize patterns. A long output stall fills the block. Random phases then
// plant intact and corrupted pattern copies into noise under random idling.
// ----------------------------------------------------------------------------
module tb_top;
	import msps_pkg::*;

	localparam int MAX_PAT      = MAX_PATTERN_DEF;
	localparam int COUNT_W      = COUNT_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 520;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 4;
	localparam int QUIET_LIMIT  = 2000;

	typedef logic [BYTE_W-1:0] byte_seq_t [$];

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             done;
	} scan_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	msps_byte_if   byte_ch ();
	msps_result_if rpt_ch ();

	masked_byte_pattern_scanner_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (byte_ch),
		.results   (rpt_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the pattern registers and the scan state
	logic [LEN_W-1:0]       pat_len = '0;
	logic [2*CFG_W-1:0]     pat_val = '0;
	logic [2*CFG_W-1:0]     pat_msk = '0;
	logic [BYTE_W-1:0]      hist [MAX_PAT] = '{default: '0};
	logic [COUNT_W-1:0]     seq_count = '0;

	scan_report_t awaited_reports [$];

	bit          src_idles = 1'b1;
	bit          sink_idles = 1'b1;
	bit          hold_pending = 1'b0;
	int unsigned fail_count = 0;
	int unsigned bytes_accepted = 0;
	int unsigned reports_checked = 0;
	int unsigned matches_checked = 0;
	int unsigned settings_applied = 0;

	// shift one byte into the window and work out the report it causes
	function automatic bit next_report(input logic [BYTE_W-1:0] b, input logic is_last,
			output scan_report_t rpt);
		int unsigned used;
		int i;
		bit wild_only;
		bit counted;
		bit hit;
		logic [COUNT_W-1:0] start;
		used = (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
		wild_only = 1'b1;
		for (i = 0; i < used; i++) begin
			if (pat_msk[8*i +: 8] != 8'h00)
				wild_only = 1'b0;
		end
		for (i = MAX_PAT - 1; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = b;
		counted = 1'b0;
		if (seq_count != {COUNT_W{1'b1}}) begin
			seq_count++;
			counted = 1'b1;
		end
		hit = 1'b0;
		start = '0;
		if (counted) begin
			if (wild_only) begin
				hit = is_last && used != 0 && seq_count == used;
			end else if (seq_count >= used) begin
				hit = 1'b1;
				for (i = 0; i < used; i++) begin
					if (((hist[used-1-i] ^ pat_val[8*i +: 8]) & pat_msk[8*i +: 8]) != 8'h00)
						hit = 1'b0;
				end
				if (hit)
					start = seq_count - used;
			end
		end
		if (is_last)
			seq_count = '0;
		rpt.found = hit;
		rpt.position = hit ? start[POS_W-1:0] : '0;
		rpt.done = is_last;
		return hit || is_last;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int unsigned idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic int unsigned sender_gap();
		if (!src_idles || $urandom_range(0, 1) == 0)
			return 0;
		return idle_len();
	endfunction

	// predict on each byte transfer, check each report transfer
	always @(posedge clk) begin : scoreboard
		scan_report_t fresh;
		scan_report_t want;
		scan_report_t got;
		if (arst_n) begin
			if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
				bytes_accepted++;
				if (next_report(byte_ch.data_byte, byte_ch.end_of_sequence, fresh))
					awaited_reports.insert(awaited_reports.size(), fresh);
			end
			if (rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) begin
				got.found = rpt_ch.match_found;
				got.position = rpt_ch.match_position;
				got.done = rpt_ch.scan_done;
				if (awaited_reports.size() == 0) begin
					$error("report with none pending: found %0b position %0d done %0b",
						got.found, got.position, got.done);
					fail_count++;
				end else begin
					want = awaited_reports.pop_front();
					reports_checked++;
					if (want.found)
						matches_checked++;
					if (got.found !== want.found) begin
						$error("match_found: expected %0b, got %0b", want.found, got.found);
						fail_count++;
					end
					if (got.position !== want.position) begin
						$error("match_position: expected %0d, got %0d",
							want.position, got.position);
						fail_count++;
					end
					if (got.done !== want.done) begin
						$error("scan_done: expected %0b, got %0b", want.done, got.done);
						fail_count++;
					end
				end
			end
		end
	end

	// result receiver: random stalls plus one requested long hold-off
	initial begin : result_sink
		rpt_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_pending) begin
				rpt_ch.ready <= 1'b0;
				hold_pending <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!sink_idles || $urandom_range(0, 2) != 0) begin
				rpt_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rpt_ch.ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
					(rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$error("no transfer for %0d cycles", QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// one byte transfer, then an optional gap
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last,
			input int unsigned gap);
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.end_of_sequence <= is_last;
		do
			@(posedge clk);
		while (byte_ch.ready !== 1'b1);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_seq(input byte_seq_t s);
		foreach (s[k])
			send_byte(s[k], k == s.size() - 1, sender_gap());
	endtask

	// stop offering, wait for every pending report, then let the pipe settle
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all five pattern registers, only while the block is idle
	task automatic set_pattern(input logic [LEN_W-1:0] len, input logic [2*CFG_W-1:0] val,
			input logic [2*CFG_W-1:0] msk);
		cfg_reg_t r;
		logic [CFG_W-1:0] word;
		r = r.first();
		repeat (r.num()) begin
			case (r)
				REG_PATTERN_LENGTH: begin
					word = {{(CFG_W-LEN_W){1'b0}}, len};
					pat_len = len;
				end
				REG_PATTERN_VALUE_LOW: begin
					word = val[CFG_W-1:0];
					pat_val[CFG_W-1:0] = word;
				end
				REG_PATTERN_VALUE_HIGH: begin
					word = val[2*CFG_W-1:CFG_W];
					pat_val[2*CFG_W-1:CFG_W] = word;
				end
				REG_PATTERN_MASK_LOW: begin
					word = msk[CFG_W-1:0];
					pat_msk[CFG_W-1:0] = word;
				end
				default: begin
					word = msk[2*CFG_W-1:CFG_W];
					pat_msk[2*CFG_W-1:CFG_W] = word;
				end
			endcase
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= word;
			@(posedge clk);
			r = r.next();
		end
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// full-mask pattern with extreme bytes: lone hit, back-to-back hits, miss
	task automatic test_exact_and_repeated();
		set_pattern(5'd4, {96'h0, 32'hA55AFF00}, '1);
		send_seq('{8'h00, 8'hFF, 8'h5A, 8'hA5});
		send_seq('{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'hFF});
		wait_drained();
	endtask

	// half-byte wildcards on both nibbles
	task automatic test_nibble_wildcards();
		set_pattern(5'd2, {112'h0, 16'h05A0}, {112'h0, 16'h0FF0});
		send_seq('{8'hAF, 8'h75});
		wait_drained();
	endtask

	// empty pattern never hits; all-wildcard pattern hits only its own length
	task automatic test_trivial_patterns();
		set_pattern(5'd0, {$urandom, $urandom, $urandom, $urandom}, '1);
		send_seq('{8'h42});
		wait_drained();
		set_pattern(5'd3, {$urandom, $urandom, $urandom, $urandom}, {{104{1'b1}}, 24'h0});
		send_seq('{8'h01, 8'h02, 8'h03});
		send_seq('{8'h04, 8'h05});
		wait_drained();
	endtask

	// length above the window clamps; a shorter sequence cannot hit
	task automatic test_oversize_pattern();
		logic [2*CFG_W-1:0] val;
		val = {$urandom, $urandom, $urandom, $urandom};
		set_pattern(5'd31, val, '1);
		send_seq('{val[7:0], val[15:8], val[23:16], val[31:24]});
		wait_drained();
	endtask

	// hit on every byte while the receiver holds off, so the input backs up
	task automatic test_output_stall();
		byte_seq_t s;
		repeat (40) s.insert(s.size(), 8'h3C);
		src_idles = 1'b0;
		sink_idles = 1'b0;
		set_pattern(5'd1, {120'h0, 8'h3C}, {120'h0, 8'hFF});
		hold_pending <= 1'b1;
		send_seq(s);
		wait_drained();
		src_idles = 1'b1;
		sink_idles = 1'b1;
	endtask

	// random settings, planted pattern copies (some corrupted) mixed with noise
	task automatic test_random_scans();
		int unsigned sent;
		int unsigned plen;
		int unsigned used;
		int unsigned target;
		int unsigned brk;
		logic [2*CFG_W-1:0] val;
		logic [2*CFG_W-1:0] msk;
		logic [BYTE_W-1:0] b;
		bit all_wild;
		byte_seq_t s;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: plen = 0;
				1: plen = $urandom_range(17, 31);
				2: plen = 16;
				default: plen = $urandom_range(1, 8);
			endcase
			used = (plen > MAX_PAT) ? MAX_PAT : plen;
			val = {$urandom, $urandom, $urandom, $urandom};
			all_wild = ($urandom_range(0, 7) == 0);
			for (int i = 0; i < MAX_PAT; i++) begin
				case ($urandom_range(0, 7))
					0: msk[8*i +: 8] = 8'h00;
					1: msk[8*i +: 8] = 8'hF0;
					2: msk[8*i +: 8] = 8'h0F;
					3: msk[8*i +: 8] = 8'($urandom);
					default: msk[8*i +: 8] = 8'hFF;
				endcase
			end
			if (all_wild)
				msk = '0;
			src_idles = ($urandom_range(0, 3) != 0);
			sink_idles = ($urandom_range(0, 3) != 0);
			set_pattern(plen[LEN_W-1:0], val, msk);
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 2) == 0)
					target = used + $urandom_range(0, 2);
				else
					target = $urandom_range(1, 3 * used + 4);
				if (target > 1 && $urandom_range(0, 1) == 0)
					target = target - 1;
				if (target == 0)
					target = 1;
				s.delete();
				while (s.size() < target) begin
					if (used != 0 && $urandom_range(0, 2) != 0) begin
						brk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, used - 1) : used;
						for (int i = 0; i < used; i++) begin
							b = (val[8*i +: 8] & msk[8*i +: 8]) | (8'($urandom) & ~msk[8*i +: 8]);
							if (i == brk)
								b = b ^ (8'h01 << $urandom_range(0, 7));
							s.insert(s.size(), b);
						end
					end else if (used != 0 && $urandom_range(0, 1) == 0) begin
						s.insert(s.size(), val[8*$urandom_range(0, used - 1) +: 8]);
					end else begin
						s.insert(s.size(), 8'($urandom_range(0, 255)));
					end
				end
				while (s.size() > target)
					void'(s.pop_back());
				send_seq(s);
				sent += s.size();
			end
			wait_drained();
		end
	endtask

	// test sequence
	initial begin
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.end_of_sequence <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PATTERN_LENGTH;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_exact_and_repeated();
		test_nibble_wildcards();
		test_trivial_patterns();
		test_oversize_pattern();
		test_output_stall();
		test_random_scans();
		wait_drained();

		$display("scanner run: %0d bytes, %0d reports checked, %0d with a match, %0d settings",
			bytes_accepted, reports_checked, matches_checked, settings_applied);
		$display("covered: exact, wildcard, empty, oversize patterns, output stall, random scans");
		if (fail_count == 0 && awaited_reports.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule : tb_top

// ===== filelist.f =====
hw/rtl/msps_pkg.sv
hw/rtl/msps_if.sv
hw/rtl/msps_match.sv
hw/rtl/masked_byte_pattern_scanner_core.sv
hw/rtl/msps_checker.sv
tb/sv/tb_top.sv
